@@ hw/rtl/ppuc_pkg.sv @@
// ppuc_pkg: shared types and constants for the PNG pixel unpack converter.
// No dependencies.
`timescale 1ns / 1ps
package ppuc_pkg;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_PAL   = 2'd1;
  localparam logic [1:0] CMD_ALPHA = 2'd2;

  localparam logic [2:0] CT_GRAY  = 3'd0;
  localparam logic [2:0] CT_RGB   = 3'd2;
  localparam logic [2:0] CT_PAL   = 3'd3;
  localparam logic [2:0] CT_GRAYA = 3'd4;
  localparam logic [2:0] CT_RGBA  = 3'd6;

  localparam logic [2:0] REG_COLOR_TYPE = 3'd0;
  localparam logic [2:0] REG_BIT_DEPTH  = 3'd1;
  localparam logic [2:0] REG_WIDTH      = 3'd2;
  localparam logic [2:0] REG_ROW_BYTES  = 3'd3;
  localparam logic [2:0] REG_HEIGHT     = 3'd4;
  localparam logic [2:0] REG_PAL_ENT    = 3'd5;
  localparam logic [2:0] REG_ALPHA_ENT  = 3'd6;
  localparam logic [2:0] REG_OUT_MODE   = 3'd7;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] table_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    logic [7:0] entry_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] gray;
    logic       last_of_run;
    logic       row_end;
    logic       image_end;
    logic       format_error;
  } out_beat_t;

  // One pixel request from the unpacker to the lookup/output stage.
  typedef struct packed {
    logic       use_pal;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last_of_run;
    logic       row_end;
    logic       image_end;
    logic       format_error;
  } pix_req_t;

endpackage

@@ hw/rtl/ppuc_ram.sv @@
// ppuc_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ppuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/ppuc_lookup.sv @@
// ppuc_lookup: palette/alpha memories, pixel colour lookup and output register.
// Depends on ppuc_pkg and ppuc_ram.
`timescale 1ns / 1ps
module ppuc_lookup #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pal_we,
  input  logic                 alpha_we,
  input  logic [7:0]           wr_idx,
  input  logic [23:0]          pal_wdata,
  input  logic [7:0]           alpha_wdata,
  input  logic [8:0]           pal_entries,
  input  logic [8:0]           alpha_entries,
  input  logic                 out_mode,
  input  logic                 req_valid,
  input  ppuc_pkg::pix_req_t   req,
  output logic                 req_stall,
  output logic                 out_valid,
  output ppuc_pkg::out_beat_t  out_data,
  input  logic                 out_stall
);
  import ppuc_pkg::*;
  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic        s1_valid_r, s1_valid_nxt;
  pix_req_t    s1_r;
  logic        s1_pal_ok_r, s1_alpha_ok_r;
  logic [23:0] pal_rd;
  logic [7:0]  alpha_rd;
  logic        s1_adv, out_load;
  logic [7:0]  r, g, b, a;
  logic [9:0]  sum;
  logic [7:0]  y;
  logic        in_range;
  out_beat_t   out_nxt;

  // stage 1 moves on when the output register is free or drains this cycle
  assign out_load  = s1_valid_r && (!out_valid || !out_stall);
  assign req_stall = s1_valid_r && !out_load;
  assign s1_adv    = req_valid && !req_stall;
  assign s1_valid_nxt = s1_adv ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign in_range  = ({1'b0, req.idx} < 9'(PALETTE_DEPTH));

  // table writes happen only between image bytes, so a read never meets a write
  ppuc_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk, .we(pal_we), .waddr(wr_idx[AW-1:0]), .wdata(pal_wdata),
    .re(s1_adv), .raddr(req.idx[AW-1:0]), .rdata(pal_rd));
  ppuc_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_alpha (
    .clk, .we(alpha_we), .waddr(wr_idx[AW-1:0]), .wdata(alpha_wdata),
    .re(s1_adv), .raddr(req.idx[AW-1:0]), .rdata(alpha_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= s1_valid_nxt;
    if (s1_adv) begin
      s1_r          <= req;
      s1_pal_ok_r   <= in_range && ({1'b0, req.idx} < pal_entries);
      s1_alpha_ok_r <= in_range && ({1'b0, req.idx} < alpha_entries);
    end
  end

  always_comb begin
    if (s1_r.use_pal) begin
      r = s1_pal_ok_r ? pal_rd[23:16] : 8'd0;
      g = s1_pal_ok_r ? pal_rd[15:8]  : 8'd0;
      b = s1_pal_ok_r ? pal_rd[7:0]   : 8'd0;
      a = s1_alpha_ok_r ? alpha_rd : 8'hff;
    end else begin
      r = s1_r.r; g = s1_r.g; b = s1_r.b; a = s1_r.a;
    end
    sum = {2'b0, r} + {2'b0, g} + {2'b0, b};
    y   = 8'((20'(sum) * 20'd683) >> 11); // exact /3 for sum < 766
    out_nxt = '0;
    if (s1_r.format_error) begin
      out_nxt.format_error = 1'b1;
      out_nxt.last_of_run  = 1'b1;
    end else begin
      out_nxt.red   = out_mode ? 8'd0 : r;
      out_nxt.green = out_mode ? 8'd0 : g;
      out_nxt.blue  = out_mode ? 8'd0 : b;
      out_nxt.gray  = out_mode ? y : 8'd0;
      out_nxt.alpha = a;
      out_nxt.last_of_run = s1_r.last_of_run;
      out_nxt.row_end     = s1_r.row_end;
      out_nxt.image_end   = s1_r.image_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) out_data <= out_nxt;
  end
endmodule

@@ hw/rtl/ppuc_unpack.sv @@
// ppuc_unpack: byte intake, row/column counters and pixel sequencing.
// Depends on ppuc_pkg.
`timescale 1ns / 1ps
module ppuc_unpack #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          color_type,
  input  logic [4:0]          bit_depth,
  input  logic [12:0]         image_width,
  input  logic [15:0]         row_bytes,
  input  logic [15:0]         image_height,
  input  logic [8:0]          pal_entries,
  input  logic                byte_valid,
  input  logic [7:0]          byte_in,
  output logic                byte_stall,
  output logic                req_valid,
  output ppuc_pkg::pix_req_t  req,
  input  logic                req_stall
);
  import ppuc_pkg::*;

  logic        busy_r, busy_nxt;
  logic [7:0]  byte_r;
  logic [2:0]  k_r, k_nxt;
  logic [2:0]  nlow_r;           // pixels this low-depth byte yields, minus one
  logic [55:0] buf_r;
  logic [3:0]  bip_r, bip_nxt;
  logic [12:0] col_r, col_nxt;
  logic [15:0] bir_r, bir_nxt;
  logic [15:0] row_r, row_nxt;
  logic [2:0]  kind;
  logic [3:0]  bpp;
  logic        low;
  logic [12:0] width;
  logic [15:0] rb, h;
  logic [2:0]  per_m1;
  logic [12:0] left;
  logic [2:0]  st;
  logic [63:0] pb;
  logic [7:0]  s, rep;
  logic        take, emit_full, last_low, row_done;

  always_comb begin
    kind = (color_type == CT_PAL && pal_entries == 9'd0) ? CT_GRAY : color_type;
    low  = (bit_depth == 5'd1 || bit_depth == 5'd2 || bit_depth == 5'd4);
    bpp  = 4'd0;
    case (kind)
      CT_GRAY:  bpp = (low || bit_depth == 5'd8) ? 4'd1 : (bit_depth == 5'd16 ? 4'd2 : 4'd0);
      CT_RGB:   bpp = (bit_depth == 5'd8) ? 4'd3 : (bit_depth == 5'd16 ? 4'd6 : 4'd0);
      CT_PAL:   bpp = (low || bit_depth == 5'd8) ? 4'd1 : 4'd0;
      CT_GRAYA: bpp = (bit_depth == 5'd8) ? 4'd2 : (bit_depth == 5'd16 ? 4'd4 : 4'd0);
      CT_RGBA:  bpp = (bit_depth == 5'd8) ? 4'd4 : (bit_depth == 5'd16 ? 4'd8 : 4'd0);
      default:  bpp = 4'd0;
    endcase
    width = (32'(image_width) < MAX_WIDTH) ? image_width : 13'(MAX_WIDTH);
    rb = (row_bytes == 16'd0) ? 16'd1 : row_bytes;
    h  = (image_height == 16'd0) ? 16'd1 : image_height;
    per_m1 = (bit_depth == 5'd1) ? 3'd7 : (bit_depth == 5'd2 ? 3'd3 : 3'd1);
    left = width - col_r - 13'd1;
    st = (bit_depth == 5'd16) ? 3'd2 : 3'd1;
  end

  // a byte is taken when the sequencer is free and the lookup stage can take a pixel
  assign byte_stall = busy_r || req_stall;
  assign take = byte_valid && !byte_stall;

  // pixel emission
  always_comb begin
    busy_nxt = busy_r; k_nxt = k_r; bip_nxt = bip_r; col_nxt = col_r;
    bir_nxt = bir_r; row_nxt = row_r;
    req_valid = 1'b0; req = '0; row_done = 1'b0;
    emit_full = 1'b0; last_low = 1'b0;
    pb = {byte_in, buf_r};
    s = '0; rep = '0;
    if (busy_r) begin
      // low-depth byte, one pixel a cycle while the lookup stage does not stall
      case (bit_depth)
        5'd1: s = {7'd0, byte_r[3'd7 - k_r]};
        5'd2: s = {6'd0, byte_r[3'd6 - {k_r[1:0], 1'b0} +: 2]};
        default: s = {4'd0, k_r[0] ? byte_r[3:0] : byte_r[7:4]};
      endcase
      case (bit_depth)
        5'd1: rep = s[0] ? 8'hff : 8'h00;
        5'd2: rep = {4{s[1:0]}};
        default: rep = {2{s[3:0]}};
      endcase
      last_low = (k_r == nlow_r);
      req_valid = 1'b1;
      req.use_pal = (kind == CT_PAL);
      req.idx = s;
      req.r = rep; req.g = rep; req.b = rep; req.a = 8'hff;
      req.row_end = (col_r + 13'd1 == width);
      req.image_end = req.row_end && ({1'b0, row_r} + 17'd1 >= {1'b0, h});
      req.last_of_run = last_low;
      if (!req_stall) begin
        col_nxt = col_r + 13'd1;
        k_nxt = k_r + 3'd1;
        if (last_low) begin
          busy_nxt = 1'b0;
          row_done = 1'b1;
        end
      end
    end else if (take) begin
      if (bpp == 4'd0) begin
        req_valid = 1'b1;
        req.format_error = 1'b1;
        req.last_of_run = 1'b1;
      end else begin
        row_done = 1'b1;
        if (col_r < width) begin
          if (low) begin
            busy_nxt = 1'b1;
            k_nxt = 3'd0;
            row_done = 1'b0;
          end else begin
            bip_nxt = bip_r + 4'd1;
            if (bip_r + 4'd1 >= bpp) begin
              emit_full = 1'b1;
              bip_nxt = 4'd0;
              if (bip_r == 4'd0) pb = {56'd0, byte_in};
              else begin
                pb = {8'd0, buf_r};
                pb[8*bip_r[2:0] +: 8] = byte_in;
              end
              req_valid = 1'b1;
              req.use_pal = (kind == CT_PAL);
              req.idx = pb[7:0];
              req.r = pb[7:0];
              req.g = (kind == CT_RGB || kind == CT_RGBA) ? pb[8*st +: 8] : pb[7:0];
              req.b = (kind == CT_RGB || kind == CT_RGBA) ? pb[16*st +: 8] : pb[7:0];
              req.a = (kind == CT_RGBA) ? pb[24*st +: 8] :
                      (kind == CT_GRAYA ? pb[8*st +: 8] : 8'hff);
              req.row_end = (col_r + 13'd1 == width);
              req.image_end = req.row_end && ({1'b0, row_r} + 17'd1 >= {1'b0, h});
              req.last_of_run = 1'b1;
              col_nxt = col_r + 13'd1;
            end
          end
        end
      end
    end
    if (row_done) begin
      bir_nxt = bir_r + 16'd1;
      if (bir_r + 16'd1 >= rb) begin
        bir_nxt = 16'd0; col_nxt = 13'd0; bip_nxt = 4'd0;
        row_nxt = (row_r + 16'd1 >= h) ? 16'd0 : row_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; k_r <= '0; bip_r <= '0; col_r <= '0; bir_r <= '0; row_r <= '0;
    end else if (!req_stall || !req_valid) begin
      busy_r <= busy_nxt; k_r <= k_nxt; bip_r <= bip_nxt; col_r <= col_nxt;
      bir_r <= bir_nxt; row_r <= row_nxt;
    end
    if (take && !busy_r && (!req_stall || !req_valid)) begin
      byte_r <= byte_in;
      nlow_r <= (left < 13'(per_m1)) ? left[2:0] : per_m1;
      if (!emit_full && bip_r < 4'd7) buf_r[8*bip_r[2:0] +: 8] <= byte_in;
    end
  end
endmodule

@@ hw/rtl/png_pixel_unpack_converter_core.sv @@
// png_pixel_unpack_converter_core: top level, config registers and table writes.
// Depends on ppuc_pkg, ppuc_unpack, ppuc_lookup (and ppuc_ram below it).
`timescale 1ns / 1ps
//
//  channel | ports                 | beat
//  --------+-----------------------+----------------------------------
//  input   | in_valid/in_stall     | in_beat_t: command and byte/entry
//  result  | out_valid/out_stall   | out_beat_t: one pixel
//  config  | cfg_psel... (APB)     | 32-bit register write/read
//
// A low-depth byte is taken at intake, then the unpack sequencer issues
// its pixels one at a time; other bytes are taken directly. Palette and
// alpha live in 256-entry RAMs with registered reads addressed by the
// pixel index, then a /3 gray stage feeds the output register. Reset
// clears counters and valids; table contents are undefined until written.
// A stall on the result side backs up through the lookup stage to in_stall;
// table writes also wait while a byte is being unpacked.
module png_pixel_unpack_converter_core #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  ppuc_pkg::in_beat_t   in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output ppuc_pkg::out_beat_t  out_data,
  input  logic                 out_stall,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import ppuc_pkg::*;

  logic [2:0]  color_type_r;
  logic [4:0]  bit_depth_r;
  logic [12:0] image_width_r;
  logic [15:0] row_bytes_r, image_height_r;
  logic [8:0]  pal_entries_r, alpha_entries_r;
  logic        out_mode_r;
  logic        cfg_wr;
  logic [2:0]  reg_sel;
  logic        byte_valid, byte_stall, pal_we, alpha_we, tbl_ok;
  logic        req_valid, req_stall;
  pix_req_t    req;

  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_type_r <= CT_GRAY; bit_depth_r <= 5'd8; image_width_r <= 13'd1;
      row_bytes_r <= 16'd1; image_height_r <= 16'd1; pal_entries_r <= '0;
      alpha_entries_r <= '0; out_mode_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'd0) begin
      case (reg_sel)
        REG_COLOR_TYPE: color_type_r    <= cfg_pwdata[2:0];
        REG_BIT_DEPTH:  bit_depth_r     <= cfg_pwdata[4:0];
        REG_WIDTH:      image_width_r   <= cfg_pwdata[12:0];
        REG_ROW_BYTES:  row_bytes_r     <= cfg_pwdata[15:0];
        REG_HEIGHT:     image_height_r  <= cfg_pwdata[15:0];
        REG_PAL_ENT:    pal_entries_r   <= cfg_pwdata[8:0];
        REG_ALPHA_ENT:  alpha_entries_r <= cfg_pwdata[8:0];
        REG_OUT_MODE:   out_mode_r      <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COLOR_TYPE: cfg_prdata = {29'd0, color_type_r};
      REG_BIT_DEPTH:  cfg_prdata = {27'd0, bit_depth_r};
      REG_WIDTH:      cfg_prdata = {19'd0, image_width_r};
      REG_ROW_BYTES:  cfg_prdata = {16'd0, row_bytes_r};
      REG_HEIGHT:     cfg_prdata = {16'd0, image_height_r};
      REG_PAL_ENT:    cfg_prdata = {23'd0, pal_entries_r};
      REG_ALPHA_ENT:  cfg_prdata = {23'd0, alpha_entries_r};
      default:        cfg_prdata = {31'd0, out_mode_r};
    endcase
  end

  // table writes go straight to the RAMs once earlier pixels have read them;
  // image bytes go to the unpacker
  assign byte_valid = in_valid && in_data.cmd == CMD_DATA;
  assign in_stall   = byte_stall;
  assign tbl_ok     = ({1'b0, in_data.table_index} < 9'(PALETTE_DEPTH));
  assign pal_we     = in_valid && !byte_stall && in_data.cmd == CMD_PAL && tbl_ok;
  assign alpha_we   = in_valid && !byte_stall && in_data.cmd == CMD_ALPHA && tbl_ok;

  ppuc_unpack #(.MAX_WIDTH(MAX_WIDTH)) u_unpack (
    .clk, .rst_n,
    .color_type(color_type_r), .bit_depth(bit_depth_r), .image_width(image_width_r),
    .row_bytes(row_bytes_r), .image_height(image_height_r), .pal_entries(pal_entries_r),
    .byte_valid, .byte_in(in_data.data_byte), .byte_stall,
    .req_valid, .req, .req_stall);

  ppuc_lookup #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_lookup (
    .clk, .rst_n, .pal_we, .alpha_we, .wr_idx(in_data.table_index),
    .pal_wdata({in_data.entry_red, in_data.entry_green, in_data.entry_blue}),
    .alpha_wdata(in_data.entry_alpha),
    .pal_entries(pal_entries_r), .alpha_entries(alpha_entries_r), .out_mode(out_mode_r),
    .req_valid, .req, .req_stall, .out_valid, .out_data, .out_stall);
endmodule

@@ tb/tb_png_pixel_unpack_converter_core.sv @@
// tb_png_pixel_unpack_converter_core: self-checking bench for the PNG pixel unpacker.
// Depends on ppuc_pkg and png_pixel_unpack_converter_core; pixels predicted in-bench.
`timescale 1ns / 1ps
module tb_png_pixel_unpack_converter_core;
  import ppuc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_beat_t    in_data = '0;
  logic        in_stall;
  logic        out_valid;
  out_beat_t   out_data;
  logic        out_stall = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  png_pixel_unpack_converter_core dut (.*);

  always #5 clk = ~clk;

  // Shadow of the block: tables, pixel assembly and row/image counters
  logic [23:0] pal_mem [256];
  logic [7:0]  alp_mem [256];
  logic [7:0]  pix_bytes [8];
  int unsigned n_pix_bytes, col, byte_pos, row;

  // Shadow of the registers
  logic [2:0]  r_ct;
  logic [4:0]  r_depth;
  logic [12:0] r_width;
  logic [15:0] r_rowb;
  logic [15:0] r_height;
  logic [8:0]  r_pal_n;
  logic [8:0]  r_alp_n;
  logic        r_mode;

  out_beat_t pixel_q [$];     // pixels still owed by the block
  int errors = 0;
  int pixels_seen = 0;
  int data_beats = 0;
  bit calm = 1'b0;            // no idling on either side while set

  // Bytes per pixel at depth >= 8, 1 for low depths, 0 if unsupported
  function automatic int unsigned pixel_size(output logic [2:0] kind);
    bit low;
    low = (r_depth == 1 || r_depth == 2 || r_depth == 4);
    kind = (r_ct == CT_PAL && r_pal_n == 0) ? CT_GRAY : r_ct;
    case (kind)
      CT_GRAY:  return (low || r_depth == 8) ? 1 : (r_depth == 16) ? 2 : 0;
      CT_RGB:   return (r_depth == 8) ? 3 : (r_depth == 16) ? 6 : 0;
      CT_PAL:   return (low || r_depth == 8) ? 1 : 0;
      CT_GRAYA: return (r_depth == 8) ? 2 : (r_depth == 16) ? 4 : 0;
      CT_RGBA:  return (r_depth == 8) ? 4 : (r_depth == 16) ? 8 : 0;
      default:  return 0;
    endcase
  endfunction

  function automatic out_beat_t make_pixel(int unsigned width, int unsigned r,
                                           int unsigned g, int unsigned b, int unsigned a);
    out_beat_t p;
    int unsigned h;
    p = '0;
    h = (r_height == 0) ? 1 : r_height;
    col++;
    if (r_mode) p.gray = 8'((r + g + b) / 3);
    else begin
      p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    end
    p.alpha = 8'(a);
    p.row_end = (col == width);
    p.image_end = p.row_end && (row + 1 >= h);
    return p;
  endfunction

  function automatic void pal_fetch(int unsigned ix, output int unsigned r,
                                    output int unsigned g, output int unsigned b,
                                    output int unsigned a);
    {r, g, b} = '0;
    if (ix < r_pal_n) begin
      r = pal_mem[ix][23:16]; g = pal_mem[ix][15:8]; b = pal_mem[ix][7:0];
    end
    a = (ix < r_alp_n) ? alp_mem[ix] : 8'hff;
  endfunction

  // Expected pixels for one accepted beat; table beats update the shadow tables
  function automatic void unpack_beat(in_beat_t bt);
    out_beat_t pix [8];
    int n, k, d, st;
    int unsigned bpp, width, per, s, r, g, b, a;
    logic [2:0] kind;
    n = 0;
    if (bt.cmd == CMD_PAL) begin
      pal_mem[bt.table_index] = {bt.entry_red, bt.entry_green, bt.entry_blue};
      return;
    end
    if (bt.cmd == CMD_ALPHA) begin
      alp_mem[bt.table_index] = bt.entry_alpha;
      return;
    end
    if (bt.cmd != CMD_DATA) return;
    bpp = pixel_size(kind);
    if (bpp == 0) begin
      pix[0] = '0;
      pix[0].format_error = 1'b1;
      pix[0].last_of_run = 1'b1;
      pixel_q.push_back(pix[0]);
      return;
    end
    width = (r_width < 4096) ? r_width : 4096;
    if (col < width) begin
      if (r_depth < 8) begin
        d = r_depth;
        per = 8 / d;
        for (k = 0; k < per && col < width; k++) begin
          s = (bt.data_byte >> (8 - d * (k + 1))) & ((1 << d) - 1);
          if (kind == CT_PAL) pal_fetch(s, r, g, b, a);
          else begin
            r = (d == 1) ? (s ? 255 : 0) : (d == 2) ? s * 8'h55 : s * 8'h11;
            g = r; b = r; a = 255;
          end
          pix[n] = make_pixel(width, r, g, b, a);
          n = n + 1;
        end
      end else begin
        pix_bytes[n_pix_bytes & 7] = bt.data_byte;
        n_pix_bytes++;
        if (n_pix_bytes >= bpp) begin
          st = r_depth / 8;
          r = pix_bytes[0]; g = r; b = r; a = 255;
          case (kind)
            CT_PAL:   pal_fetch(pix_bytes[0], r, g, b, a);
            CT_RGB:   begin
              g = pix_bytes[st & 7]; b = pix_bytes[(2 * st) & 7];
            end
            CT_GRAYA: a = pix_bytes[st & 7];
            CT_RGBA:  begin
              g = pix_bytes[st & 7]; b = pix_bytes[(2 * st) & 7];
              a = pix_bytes[(3 * st) & 7];
            end
            default: ;
          endcase
          pix[n] = make_pixel(width, r, g, b, a);
          n = n + 1;
          n_pix_bytes = 0;
        end
      end
    end
    byte_pos++;
    if (byte_pos >= ((r_rowb == 0) ? 1 : r_rowb)) begin
      byte_pos = 0; col = 0; n_pix_bytes = 0;
      row++;
      if (row >= ((r_height == 0) ? 1 : r_height)) row = 0;
    end
    if (n > 0) pix[n - 1].last_of_run = 1'b1;
    for (k = 0; k < n; k++) pixel_q.push_back(pix[k]);
  endfunction

  // Result side: random stall, compare each accepted pixel with the oldest owed
  always @(posedge clk) begin
    out_stall <= !calm && rst_n && ($urandom_range(99) < 12);
  end

  function automatic void check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $error("pixel beat with nothing expected");
        errors++;
      end else begin
        e = pixel_q.pop_front();
        check_field("red", e.red, out_data.red);
        check_field("green", e.green, out_data.green);
        check_field("blue", e.blue, out_data.blue);
        check_field("alpha", e.alpha, out_data.alpha);
        check_field("gray", e.gray, out_data.gray);
        check_field("last_of_run", e.last_of_run, out_data.last_of_run);
        check_field("row_end", e.row_end, out_data.row_end);
        check_field("image_end", e.image_end, out_data.image_end);
        check_field("format_error", e.format_error, out_data.format_error);
      end
    end
  end

  // Input side: valid stays up between back-to-back beats, dropped only for gaps
  task automatic send_beat(in_beat_t bt);
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= bt;
    do @(posedge clk); while (in_stall !== 1'b0);
    unpack_beat(bt);
    if (bt.cmd == CMD_DATA) data_beats++;
  endtask

  task automatic send_byte(logic [7:0] v);
    in_beat_t bt;
    bt = 50'({$urandom, $urandom});
    bt.cmd = CMD_DATA;
    bt.data_byte = v;
    send_beat(bt);
  endtask

  // Drain: all owed pixels out, then room for a last pixel-less byte in flight
  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_COLOR_TYPE: r_ct = val[2:0];
      REG_BIT_DEPTH:  r_depth = val[4:0];
      REG_WIDTH:      r_width = val[12:0];
      REG_ROW_BYTES:  r_rowb = val[15:0];
      REG_HEIGHT:     r_height = val[15:0];
      REG_PAL_ENT:    r_pal_n = val[8:0];
      REG_ALPHA_ENT:  r_alp_n = val[8:0];
      default:        r_mode = val[0];
    endcase
  endtask

  task automatic set_format(int ct, int depth, int width, int rowb, int height,
                            int paln, int alpn, int mode);
    drain();
    reg_write(REG_COLOR_TYPE, ct);
    reg_write(REG_BIT_DEPTH, depth);
    reg_write(REG_WIDTH, width);
    reg_write(REG_ROW_BYTES, rowb);
    reg_write(REG_HEIGHT, height);
    reg_write(REG_PAL_ENT, paln);
    reg_write(REG_ALPHA_ENT, alpn);
    reg_write(REG_OUT_MODE, mode);
  endtask

  // Fill the low half of both tables; palette images never use more entries
  task automatic test_table_fill;
    in_beat_t bt;
    for (int i = 0; i < 128; i++) begin
      bt = 50'({$urandom, $urandom});
      bt.cmd = CMD_PAL; bt.table_index = 8'(i);
      send_beat(bt);
      bt = 50'({$urandom, $urandom});
      bt.cmd = CMD_ALPHA; bt.table_index = 8'(i);
      if (i == 0) bt.entry_alpha = 8'h00;
      send_beat(bt);
    end
    bt = 50'({$urandom, $urandom});
    bt.cmd = 2'd3;               // unknown command, ignored
    send_beat(bt);
  endtask

  task automatic test_low_depth_gray;
    set_format(CT_GRAY, 1, 8, 1, 2, 0, 0, 0);
    send_byte(8'hA5); send_byte(8'h00); send_byte(8'hFF);
    set_format(CT_GRAY, 2, 4, 1, 1, 0, 0, 1);
    send_byte(8'h1B);
    set_format(CT_GRAY, 4, 3, 2, 1, 0, 0, 0);
    send_byte(8'hF0); send_byte(8'h3C);
  endtask

  task automatic test_deep_formats;
    set_format(CT_GRAY, 16, 1, 2, 1, 0, 0, 1);
    send_byte(8'hFF); send_byte(8'h00);
    set_format(CT_RGB, 16, 1, 6, 1, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_byte(8'(8'h30 * i));
    set_format(CT_RGBA, 8, 1, 5, 1, 0, 0, 0);   // one padding byte
    for (int i = 0; i < 5; i++) send_byte(8'($urandom));
    set_format(CT_GRAYA, 8, 1, 2, 1, 0, 0, 1);
    send_byte(8'h80); send_byte(8'h7F);
  endtask

  // Out-of-range indexes, empty palette as gray
  task automatic test_palette;
    set_format(CT_PAL, 1, 8, 1, 1, 1, 1, 0);
    send_byte(8'h5F);
    set_format(CT_PAL, 8, 2, 2, 1, 128, 0, 0);
    send_byte(8'hFF); send_byte(8'h00);
    set_format(CT_PAL, 4, 2, 1, 1, 256, 256, 1);
    send_byte(8'h0F);
    set_format(CT_PAL, 16, 1, 2, 1, 0, 0, 0);
    send_byte(8'hC3); send_byte(8'h11);
  endtask

  task automatic test_bad_formats;
    set_format(1, 8, 1, 1, 1, 0, 0, 0);
    send_byte(8'h12);
    set_format(CT_RGB, 4, 1, 1, 1, 0, 0, 0);
    send_byte(8'h34);
    set_format(7, 31, 1, 1, 1, 0, 0, 0);
    send_byte(8'h56);
    set_format(CT_PAL, 16, 1, 1, 1, 4, 4, 0);
    send_byte(8'h78);
  endtask

  // Width zero and beyond the maximum, short rows, zero sizes
  task automatic test_row_geometry;
    set_format(CT_GRAY, 8, 0, 2, 1, 0, 0, 0);
    send_byte(8'h01); send_byte(8'h02);
    set_format(CT_GRAY, 1, 8191, 2, 1, 0, 0, 0);
    send_byte(8'hAA); send_byte(8'h55);
    set_format(CT_RGB, 8, 2, 4, 2, 0, 0, 0);    // row stops mid-pixel
    for (int i = 0; i < 8; i++) send_byte(8'($urandom));
    set_format(CT_GRAY, 8, 1, 0, 0, 0, 0, 0);
    send_byte(8'hEE); send_byte(8'h44);
    set_format(CT_GRAY, 8, 4096, 32768, 65535, 256, 256, 1);
    send_byte(8'h99);
  endtask

  task automatic test_random_images;
    int ct, depth, width, rowb, height, chans, nbytes, phase, calm_phase;
    in_beat_t bt;
    phase = 0;
    calm_phase = $urandom_range(2, 1);
    while (data_beats < 240) begin
      case ($urandom_range(5))
        0: ct = CT_GRAY;  1: ct = CT_RGB;  2: ct = CT_PAL;
        3: ct = CT_GRAYA; 4: ct = CT_RGBA;
        default: ct = $urandom_range(7);
      endcase
      case ($urandom_range(5))
        0: depth = 1; 1: depth = 2; 2: depth = 4; 3: depth = 8; 4: depth = 16;
        default: depth = ($urandom_range(9) == 0) ? $urandom_range(31) : 8;
      endcase
      chans = (ct == CT_RGB) ? 3 : (ct == CT_GRAYA) ? 2 : (ct == CT_RGBA) ? 4 : 1;
      width = $urandom_range(12, 1);
      rowb = (width * chans * depth + 7) / 8;
      rowb = ($urandom_range(7) == 0) ? $urandom_range(rowb, 1) : rowb + $urandom_range(2);
      height = $urandom_range(4, 1);
      set_format(ct, depth, width, rowb, height, $urandom_range(128),
                 $urandom_range(128), $urandom_range(1));
      calm = (phase == calm_phase);
      nbytes = rowb * height * $urandom_range(2, 1);
      if (nbytes > 40) nbytes = 40;
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(99) < 5) begin
          bt = 50'({$urandom, $urandom});   // table rewrite or unknown command
          bt.cmd = 2'($urandom_range(3, 1));
          send_beat(bt);
        end
        send_byte(8'($urandom));
      end
      calm = 1'b0;
      phase++;
    end
  endtask

  initial begin
    n_pix_bytes = 0; col = 0; byte_pos = 0; row = 0;
    r_ct = CT_GRAY; r_depth = 8; r_width = 1; r_rowb = 1;
    r_height = 1; r_pal_n = 0; r_alp_n = 0; r_mode = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_low_depth_gray();
    test_deep_formats();
    test_palette();
    test_bad_formats();
    test_row_geometry();
    test_random_images();
    drain();
    $display("Covered %0d image bytes across all colour types and depths, %0d pixels checked.",
             data_beats, pixels_seen);
    if (errors == 0)
      $display("PASS png_pixel_unpack_converter_core");
    else
      $display("FAIL png_pixel_unpack_converter_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL png_pixel_unpack_converter_core");
    $finish;
  end

endmodule
